/* rtl/mtlb_pkg.sv */
`timescale 1ns / 1ps
// Package for the TLB translate and check block: request codes, fault codes,
// entry layout and the permission helpers. Depends on nothing.
package mtlb_pkg;

  localparam int unsigned TlbDepthDef = 64;

  localparam logic [3:0]  CtrlReset   = 4'd0;
  localparam logic [17:0] TbaseReset  = 18'd228023;
  localparam logic [31:0] DaccReset   = 32'hDEADC0DE;

  // Register indexes on the write port
  localparam logic [1:0] CfgCtrl  = 2'd0;
  localparam logic [1:0] CfgTbase = 2'd1;
  localparam logic [1:0] CfgDacc  = 2'd2;

  typedef enum logic [1:0] {
    OP_ACCESS  = 2'd0,
    OP_RESP    = 2'd1,
    OP_INV_ALL = 2'd2,
    OP_INV_ONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    FLT_NONE     = 3'd0,
    FLT_ALIGN    = 3'd1,
    FLT_SECT_XL  = 3'd2,
    FLT_PAGE_XL  = 3'd3,
    FLT_DOMAIN   = 3'd4,
    FLT_SECT_PRM = 3'd5,
    FLT_SUB_PRM  = 3'd6
  } fault_e;

  typedef enum logic [1:0] {
    EK_INVALID = 2'd0,
    EK_SMALL   = 2'd1,
    EK_LARGE   = 2'd2,
    EK_SECTION = 2'd3
  } ekind_e;

  typedef enum logic [1:0] {
    WK_IDLE = 2'd0,
    WK_L1   = 2'd1,
    WK_L2   = 2'd2
  } walk_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOOK = 2'd1,
    ST_EMIT = 2'd2
  } ctl_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_DIRECT = 2'd1,
    ACT_FINISH = 2'd2
  } act_e;

  // Descriptor type field codes
  localparam logic [1:0] DT_FAULT = 2'd0;
  localparam logic [1:0] DT_COARSE = 2'd1;
  localparam logic [1:0] DT_SECT  = 2'd2;
  localparam logic [1:0] DT_RSVD  = 2'd3;

  // Domain access codes
  localparam logic [1:0] DA_CLIENT  = 2'd1;
  localparam logic [1:0] DA_MANAGER = 2'd3;

  typedef struct packed {
    logic [19:0] vbase;
    logic [19:0] pbase;
    logic [9:0]  perm;
    logic [3:0]  dom;
    ekind_e      kind;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    fault_e      fault;
    logic [3:0]  dom;
    logic        cache;
  } res_t;

  // Page-number mask (address bits 31..12) for an entry kind
  function automatic logic [19:0] page_mask(ekind_e k);
    logic [19:0] m;
    unique case (k)
      EK_SMALL:   m = 20'hFFFFF;
      EK_LARGE:   m = 20'hFFFF0;
      EK_SECTION: m = 20'hFFF00;
      default:    m = 20'h00000;
    endcase
    return m;
  endfunction

  function automatic logic perm_ok(logic [1:0] ap, logic rd, logic usr,
                                   logic sys_p, logic rom_p);
    logic ok;
    unique case (ap)
      2'd0:    ok = rd && ((sys_p && !usr) || rom_p);
      2'd1:    ok = !usr;
      2'd2:    ok = rd || !usr;
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

/* rtl/mtlb_cell.sv */
`timescale 1ns / 1ps
// One TLB entry cell: holds an entry, matches the lookup address and passes
// the first hit down the row. Depends on mtlb_pkg.
module mtlb_cell import mtlb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] va_i,
  input  logic        hit_i,
  input  entry_t      sel_i,
  output logic        hit_o,
  output entry_t      sel_o,
  input  logic        wr_i,
  input  entry_t      wr_entry_i,
  input  logic        clr_all_i,
  input  logic        clr_first_i
);

  entry_t      ent_q;
  ekind_e      kind_q, kind_d;
  logic [19:0] msk;
  logic        match;

  // Match against this entry
  assign msk   = page_mask(kind_q);
  assign match = (kind_q != EK_INVALID) && ((va_i[31:12] & msk) == (ent_q.vbase & msk));

  // Pass the first hit along the row
  assign hit_o = hit_i | match;
  always_comb begin
    sel_o      = hit_i ? sel_i : ent_q;
    sel_o.kind = hit_i ? sel_i.kind : kind_q;
  end

  // Advance the kind: fill, clear all, or clear on first match
  always_comb begin
    kind_d = kind_q;
    if (clr_all_i) begin
      kind_d = EK_INVALID;
    end else if (clr_first_i && match && !hit_i) begin
      kind_d = EK_INVALID;
    end else if (wr_i) begin
      kind_d = wr_entry_i.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= EK_INVALID;
    end else begin
      kind_q <= kind_d;
    end
  end

  // Hold the payload until the next fill
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      ent_q <= wr_entry_i;
    end
  end

endmodule

/* rtl/mtlb_check.sv */
`timescale 1ns / 1ps
// Domain and access-permission check of one selected entry, forming the
// finished translation. Depends on mtlb_pkg.
module mtlb_check import mtlb_pkg::*; (
  input  entry_t      ent_i,
  input  logic [31:0] va_i,
  input  logic        rd_i,
  input  logic        usr_i,
  input  logic [3:0]  ctrl_i,
  input  logic [31:0] dacc_i,
  output res_t        res_o
);

  logic [1:0]  acc;
  logic [1:0]  sub;
  logic [1:0]  ap;
  logic [19:0] msk;

  assign acc = dacc_i[{ent_i.dom, 1'b0} +: 2];
  assign msk = page_mask(ent_i.kind);

  // Pick the subpage permission field
  always_comb begin
    unique case (ent_i.kind)
      EK_SMALL: sub = va_i[11:10];
      EK_LARGE: sub = va_i[15:14];
      default:  sub = 2'd3;
    endcase
    ap = ent_i.perm[{1'b0, sub, 1'b0} + 4'd2 +: 2];
  end

  // Form the answer
  always_comb begin
    res_o.kind  = 1'b0;
    res_o.dom   = ent_i.dom;
    res_o.cache = ent_i.perm[1];
    res_o.fault = FLT_NONE;
    res_o.addr  = {(ent_i.pbase & msk) | (va_i[31:12] & ~msk), va_i[11:0]};
    if (acc != DA_CLIENT && acc != DA_MANAGER) begin
      res_o.fault = FLT_DOMAIN;
      res_o.addr  = va_i;
    end else if (acc == DA_CLIENT && !perm_ok(ap, rd_i, usr_i, ctrl_i[2], ctrl_i[3])) begin
      res_o.fault = (ent_i.kind == EK_SECTION) ? FLT_SECT_PRM : FLT_SUB_PRM;
      res_o.addr  = va_i;
    end
  end

endmodule

/* rtl/mmu_tlb_translate_check.sv */
`timescale 1ns / 1ps
// Top level: TLB cell row, walk control and result register.
// Depends on mtlb_pkg, mtlb_cell and mtlb_check.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------
//  request   | start / busy         | opcode, virtual_address, descriptor,
//            |                      | is_read, user_mode
//  result    | strobe_o (one cycle) | kind, out_address, fault, domain,
//            |                      | cacheable
//  config    | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// A request is accepted at a rising edge while idle. In ST_LOOK it is looked
// up in the cell row (first hit ripples down the row) and the walk state is
// settled; in ST_EMIT domain and permissions are checked and the result
// register and strobe are loaded, and a new request is accepted only once the
// sequencer is back in ST_IDLE. Reset clears the entry kinds, walk state and
// configuration registers at once; there is no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.
module mmu_tlb_translate_check import mtlb_pkg::*; #(
  parameter int unsigned TLB_DEPTH = TlbDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] virtual_address_i,
  input  logic [31:0] descriptor_i,
  input  logic        is_read_i,
  input  logic        user_mode_i,
  output logic        strobe_o,
  output logic        kind_o,
  output logic [31:0] out_address_o,
  output logic [2:0]  fault_o,
  output logic [3:0]  domain_o,
  output logic        cacheable_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned IdxW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TLB_DEPTH - 1);

  ctl_e st_q, st_d;

  logic [3:0]  ctrl_q;
  logic [17:0] tbase_q;
  logic [31:0] dacc_q;

  op_e         op_q;
  logic [31:0] va_q, desc_q;
  logic        rd_q, usr_q;

  walk_e       walk_q, walk_d;
  logic [31:0] paddr_q, paddr_d;
  logic        prd_q, prd_d, pusr_q, pusr_d;
  logic [3:0]  pdom_q, pdom_d;
  logic [IdxW-1:0] rp_q, rp_d;

  act_e        act_q, act_d;
  res_t        dres_q, dres_d;
  entry_t      fent_q, fent_d;
  logic [31:0] fva_q, fva_d;
  logic        frd_q, frd_d, fusr_q, fusr_d;

  res_t        out_q, chk_res;
  logic        strobe_q;

  logic        look, fill, clr_all, clr_first;
  entry_t      fill_ent;
  logic [TLB_DEPTH:0] hit_c;
  entry_t      sel_c [TLB_DEPTH+1];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= CtrlReset;
      tbase_q <= TbaseReset;
      dacc_q  <= DaccReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCtrl:  ctrl_q  <= cfg_data_i[3:0];
        CfgTbase: tbase_q <= cfg_data_i[17:0];
        CfgDacc:  dacc_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    unique case (st_q)
      ST_IDLE: st_d = start ? ST_LOOK : ST_IDLE;
      ST_LOOK: st_d = ST_EMIT;
      ST_EMIT: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy = (st_q != ST_IDLE);
    look = (st_q == ST_LOOK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q   <= op_e'(opcode_i);
      va_q   <= virtual_address_i;
      desc_q <= descriptor_i;
      rd_q   <= is_read_i;
      usr_q  <= user_mode_i;
    end
  end

  // Cell row
  assign hit_c[0] = 1'b0;
  assign sel_c[0] = '0;
  for (genvar i = 0; i < TLB_DEPTH; i++) begin : g_cell
    mtlb_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .va_i        (va_q),
      .hit_i       (hit_c[i]),
      .sel_i       (sel_c[i]),
      .hit_o       (hit_c[i+1]),
      .sel_o       (sel_c[i+1]),
      .wr_i        (fill && (rp_q == IdxW'(i))),
      .wr_entry_i  (fill_ent),
      .clr_all_i   (clr_all),
      .clr_first_i (clr_first)
    );
  end

  // Decide the action in the lookup cycle
  always_comb begin
    walk_d   = walk_q;
    paddr_d  = paddr_q;
    prd_d    = prd_q;
    pusr_d   = pusr_q;
    pdom_d   = pdom_q;
    rp_d     = rp_q;
    act_d    = ACT_NONE;
    dres_d   = '{kind: 1'b0, addr: va_q, fault: FLT_NONE, dom: pdom_q, cache: 1'b0};
    fent_d   = sel_c[TLB_DEPTH];
    fva_d    = va_q;
    frd_d    = rd_q;
    fusr_d   = usr_q;
    fill     = 1'b0;
    clr_all  = 1'b0;
    clr_first = 1'b0;
    fill_ent = '0;
    fill_ent.vbase = paddr_q[31:12];
    fill_ent.pbase = desc_q[31:12];
    fill_ent.perm  = desc_q[11:2];
    fill_ent.dom   = pdom_q;
    fill_ent.kind  = (desc_q[1:0] == DT_COARSE) ? EK_LARGE : EK_SMALL;
    if (walk_q == WK_L1) begin
      fill_ent.perm = desc_q[11:2] & 10'h303;
      fill_ent.dom  = desc_q[8:5];
      fill_ent.kind = EK_SECTION;
    end
    fill_ent.vbase = fill_ent.vbase & page_mask(fill_ent.kind);
    fill_ent.pbase = fill_ent.pbase & page_mask(fill_ent.kind);
    if (look) begin
      unique case (op_q)
        OP_INV_ALL: begin
          clr_all = 1'b1;
          rp_d    = '0;
        end
        OP_INV_ONE: clr_first = 1'b1;
        OP_ACCESS: begin
          if (walk_q != WK_IDLE) begin
            act_d = ACT_NONE;
          end else if (!ctrl_q[0]) begin
            act_d = ACT_DIRECT;
          end else if (ctrl_q[1] && (va_q[1:0] != 2'd0)) begin
            act_d        = ACT_DIRECT;
            dres_d.fault = FLT_ALIGN;
          end else if (hit_c[TLB_DEPTH]) begin
            act_d = ACT_FINISH;
          end else begin
            act_d       = ACT_DIRECT;
            dres_d.kind = 1'b1;
            dres_d.addr = {tbase_q, va_q[31:20], 2'b00};
            walk_d      = WK_L1;
            paddr_d     = va_q;
            prd_d       = rd_q;
            pusr_d      = usr_q;
          end
        end
        OP_RESP: begin
          fva_d  = paddr_q;
          frd_d  = prd_q;
          fusr_d = pusr_q;
          fent_d = fill_ent;
          if (walk_q == WK_L1) begin
            walk_d = WK_IDLE;
            if (desc_q[1:0] == DT_SECT) begin
              fill  = 1'b1;
              act_d = ACT_FINISH;
            end else if (desc_q[1:0] == DT_COARSE) begin
              walk_d      = WK_L2;
              pdom_d      = desc_q[8:5];
              act_d       = ACT_DIRECT;
              dres_d.kind = 1'b1;
              dres_d.dom  = desc_q[8:5];
              dres_d.addr = {desc_q[31:10], paddr_q[19:12], 2'b00};
            end else begin
              act_d        = ACT_DIRECT;
              dres_d.addr  = paddr_q;
              dres_d.fault = FLT_SECT_XL;
            end
          end else if (walk_q == WK_L2) begin
            walk_d = WK_IDLE;
            if (desc_q[1:0] == DT_COARSE || desc_q[1:0] == DT_SECT) begin
              fill  = 1'b1;
              act_d = ACT_FINISH;
            end else begin
              act_d        = ACT_DIRECT;
              dres_d.addr  = paddr_q;
              dres_d.fault = FLT_PAGE_XL;
            end
          end
        end
        default: ;
      endcase
      if (fill) begin
        rp_d = (rp_q == IdxLast) ? '0 : rp_q + 1'b1;
      end
    end
  end

  // Check the selected entry
  mtlb_check u_check (
    .ent_i  (fent_q),
    .va_i   (fva_q),
    .rd_i   (frd_q),
    .usr_i  (fusr_q),
    .ctrl_i (ctrl_q),
    .dacc_i (dacc_q),
    .res_o  (chk_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q   <= WK_IDLE;
      paddr_q  <= '0;
      prd_q    <= 1'b0;
      pusr_q   <= 1'b0;
      pdom_q   <= '0;
      rp_q     <= '0;
      act_q    <= ACT_NONE;
      strobe_q <= 1'b0;
    end else begin
      walk_q   <= walk_d;
      paddr_q  <= paddr_d;
      prd_q    <= prd_d;
      pusr_q   <= pusr_d;
      rp_q     <= rp_d;
      act_q    <= act_d;
      strobe_q <= (st_q == ST_EMIT) && (act_q != ACT_NONE);
      if ((st_q == ST_EMIT) && (act_q == ACT_FINISH)) begin
        pdom_q <= fent_q.dom;
      end else begin
        pdom_q <= pdom_d;
      end
    end
  end

  // Hold the lookup result and drive the answer register
  always_ff @(posedge clk_i) begin
    if (look) begin
      dres_q <= dres_d;
      fent_q <= fent_d;
      fva_q  <= fva_d;
      frd_q  <= frd_d;
      fusr_q <= fusr_d;
    end
    if (st_q == ST_EMIT) begin
      out_q <= (act_q == ACT_FINISH) ? chk_res : dres_q;
    end
  end

  assign strobe_o      = strobe_q;
  assign kind_o        = out_q.kind;
  assign out_address_o = out_q.addr;
  assign fault_o       = out_q.fault;
  assign domain_o      = out_q.dom;
  assign cacheable_o   = out_q.cache;

endmodule
